// File: design/pus_pkg.sv
// Shared types, codes and sizing for the PWM update bus write sequencer.
package pus_pkg;

  localparam int CHANNELS     = 4;
  localparam int BYTES_PER_CH = 4;
  localparam int TOTAL_BYTES  = CHANNELS * BYTES_PER_CH;
  localparam int IDX_W        = $clog2(TOTAL_BYTES + 1);
  localparam int CHF_W        = IDX_W - 2;
  localparam int INPUT_CH     = 4;

  localparam int PCT_W   = 15;
  localparam int COUNT_W = 12;
  localparam int ADDR_W  = 7;
  localparam int REG_W   = 8;
  localparam int CFG_W   = 12;

  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // Clamp limit (100.0 percent in Q8) and saturation limit of an off count.
  localparam pct_t   PCT_MAX   = 15'd25600;
  localparam count_t COUNT_MAX = 12'd4095;

  // floor(q * 41 / 5120) == (q * RECIP_MUL) >> RECIP_SH for all q <= 25600.
  localparam int          RECIP_SH  = 27;
  localparam int          RECIP_W   = 21;
  localparam logic [20:0] RECIP_MUL = 21'd1074791;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_START_REGISTER = 2'd1;
  localparam logic [1:0] CFG_ZERO_OFFSET    = 2'd2;

  // Input command codes.
  localparam logic CMD_SEND  = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // Bus status codes.
  localparam logic [1:0] ST_START_DONE = 2'd0;
  localparam logic [1:0] ST_ADDR_ACK   = 2'd1;
  localparam logic [1:0] ST_BYTE_SENT  = 2'd2;
  localparam logic [1:0] ST_OTHER      = 2'd3;

  // Reply codes.
  localparam logic [1:0] RPL_NONE     = 2'd0;
  localparam logic [1:0] RPL_ACCEPTED = 2'd1;
  localparam logic [1:0] RPL_BUSY     = 2'd2;
  localparam logic [1:0] RPL_ERROR    = 2'd3;

  // Bus action codes.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_ADDR  = 3'd2;
  localparam logic [2:0] ACT_BYTE  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  // Byte positions inside one channel's four-byte group.
  localparam logic [1:0] POS_OFF_LO = 2'd2;
  localparam logic [1:0] POS_OFF_HI = 2'd3;

  // Control from the sequencer to the channel lanes.
  typedef struct packed {
    logic load;
  } lane_ctrl_t;

endpackage

// File: design/pwm_update_i2c_sequencer_core.sv
// Top level of the PWM update bus write sequencer: config, lanes and sequencer.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    command, four motor percents, bus status
//  out_     output     out_valid/out_ready  reply, bus action, tx byte, busy, error
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One word is accepted per cycle while in_ready is high; its result word appears in
// the output register in the next cycle. Lanes and sequencer decision are registered.
// in_ready stays high while the output register is empty or being drained, so a
// stalled out_ready holds one result word and blocks only further input.
// Reset (rst_n low, synchronous) clears busy, error, byte index, off counts and
// restores the register defaults.
module pwm_update_i2c_sequencer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  pus_pkg::pct_t             in_motor_a_percent,
  input  pus_pkg::pct_t             in_motor_b_percent,
  input  pus_pkg::pct_t             in_motor_c_percent,
  input  pus_pkg::pct_t             in_motor_d_percent,
  input  logic [1:0]                in_bus_status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_reply,
  output logic [2:0]                out_bus_action,
  output logic [7:0]                out_tx_byte,
  output logic                      out_busy_flag,
  output logic                      out_error_flag,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pus_pkg::CFG_W-1:0] cfg_wdata
);
  import pus_pkg::*;

  logic [ADDR_W-1:0] slave_address_r;
  logic [REG_W-1:0]  start_register_r;
  count_t            zero_offset_r;
  logic              accept;
  logic              out_take;
  lane_ctrl_t        ctrl;
  pct_t              pct_in [INPUT_CH];
  count_t            counts [CHANNELS];

  // Configuration registers; take a write on any cycle with cfg_we high.
  // Write them only while no word is in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r  <= ADDR_W'(79);
      start_register_r <= REG_W'(6);
      zero_offset_r    <= COUNT_W'(205);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDRESS:  slave_address_r  <= cfg_wdata[ADDR_W-1:0];
        CFG_START_REGISTER: start_register_r <= cfg_wdata[REG_W-1:0];
        CFG_ZERO_OFFSET:    zero_offset_r    <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance whenever the result register is free or being taken this cycle.
  assign out_take = out_valid & out_ready;
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  assign pct_in[0] = in_motor_a_percent;
  assign pct_in[1] = in_motor_b_percent;
  assign pct_in[2] = in_motor_c_percent;
  assign pct_in[3] = in_motor_d_percent;

  // One lane per channel; channels past the four input ports see zero percent.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    pct_t lane_pct;
    if (ch < INPUT_CH) begin : g_src
      assign lane_pct = pct_in[ch];
    end else begin : g_zero
      assign lane_pct = '0;
    end
    pus_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .pct         (lane_pct),
      .zero_offset (zero_offset_r),
      .count       (counts[ch])
    );
  end

  pus_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .command        (in_command),
    .bus_status     (in_bus_status),
    .out_take       (out_take),
    .slave_address  (slave_address_r),
    .start_register (start_register_r),
    .counts         (counts),
    .ctrl           (ctrl),
    .out_valid      (out_valid),
    .reply          (out_reply),
    .bus_action     (out_bus_action),
    .tx_byte        (out_tx_byte),
    .busy_flag      (out_busy_flag),
    .error_flag     (out_error_flag)
  );

endmodule

// File: design/pus_lane.sv
// One channel lane: clamp a percentage, convert it to an off count and hold it.
module pus_lane (
  input  logic            clk,
  input  logic            rst_n,
  input  pus_pkg::lane_ctrl_t ctrl,
  input  pus_pkg::pct_t   pct,
  input  pus_pkg::count_t zero_offset,
  output pus_pkg::count_t count
);
  import pus_pkg::*;

  pct_t                          pct_clamped;
  logic [PCT_W+RECIP_W-1:0]      prod;
  logic [COUNT_W:0]              sum;
  count_t                        count_nxt;
  count_t                        count_r;

  always_comb begin
    pct_clamped = (pct > PCT_MAX) ? PCT_MAX : pct;
    prod        = (PCT_W+RECIP_W)'(pct_clamped) * (PCT_W+RECIP_W)'(RECIP_MUL);
    sum         = (COUNT_W+1)'(prod >> RECIP_SH) + (COUNT_W+1)'(zero_offset);
    // Saturate at the top of the counter range.
    count_nxt   = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.load) begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

// File: design/pus_seq.sv
// Request and bus event sequencer, byte merge from the lanes and result register.
module pus_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                command,
  input  logic [1:0]          bus_status,
  input  logic                out_take,
  input  logic [pus_pkg::ADDR_W-1:0] slave_address,
  input  logic [pus_pkg::REG_W-1:0]  start_register,
  input  pus_pkg::count_t     counts [pus_pkg::CHANNELS],
  output pus_pkg::lane_ctrl_t ctrl,
  output logic                out_valid,
  output logic [1:0]          reply,
  output logic [2:0]          bus_action,
  output logic [7:0]          tx_byte,
  output logic                busy_flag,
  output logic                error_flag
);
  import pus_pkg::*;

  logic       busy_r,   busy_nxt;
  logic       failed_r, failed_nxt;
  idx_t       idx_r,    idx_nxt;
  logic       valid_r;
  logic [1:0] reply_r,  reply_nxt;
  logic [2:0] action_r, action_nxt;
  logic [7:0] tx_r,     tx_nxt;
  logic       load;
  count_t     sel_count;
  logic [7:0] data_byte;

  // Pick the count of the channel that the byte index points at.
  always_comb begin
    sel_count = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (idx_r[IDX_W-1:2] == CHF_W'(ch)) begin
        sel_count = counts[ch];
      end
    end
    if (idx_r >= idx_t'(TOTAL_BYTES)) begin
      data_byte = '0;
    end else if (idx_r[1:0] == POS_OFF_LO) begin
      data_byte = sel_count[7:0];
    end else if (idx_r[1:0] == POS_OFF_HI) begin
      data_byte = 8'(sel_count >> 8);
    end else begin
      data_byte = '0;
    end
  end

  always_comb begin
    busy_nxt   = busy_r;
    failed_nxt = failed_r;
    idx_nxt    = idx_r;
    reply_nxt  = RPL_NONE;
    action_nxt = ACT_NONE;
    tx_nxt     = '0;
    load       = 1'b0;
    if (command == CMD_SEND) begin
      priority if (busy_r) begin
        reply_nxt = RPL_BUSY;
      end else if (failed_r) begin
        reply_nxt = RPL_ERROR;
      end else begin
        load       = accept;
        busy_nxt   = 1'b1;
        reply_nxt  = RPL_ACCEPTED;
        action_nxt = ACT_START;
      end
    end else begin
      unique case (bus_status)
        ST_START_DONE: begin
          action_nxt = ACT_ADDR;
          tx_nxt     = {slave_address, 1'b0};
        end
        ST_ADDR_ACK: begin
          action_nxt = ACT_BYTE;
          tx_nxt     = start_register;
        end
        ST_BYTE_SENT: begin
          if (idx_r >= idx_t'(TOTAL_BYTES)) begin
            action_nxt = ACT_STOP;
            idx_nxt    = '0;
            busy_nxt   = 1'b0;
          end else begin
            action_nxt = ACT_BYTE;
            tx_nxt     = data_byte;
            idx_nxt    = idx_r + idx_t'(1);
          end
        end
        default: begin
          busy_nxt   = 1'b0;
          failed_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      failed_r <= 1'b0;
      idx_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        busy_r   <= busy_nxt;
        failed_r <= failed_nxt;
        idx_r    <= idx_nxt;
        valid_r  <= 1'b1;
      end else if (out_take) begin
        valid_r  <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      reply_r  <= reply_nxt;
      action_r <= action_nxt;
      tx_r     <= tx_nxt;
    end
  end

  assign ctrl.load  = load;
  assign out_valid  = valid_r;
  assign reply      = reply_r;
  assign bus_action = action_r;
  assign tx_byte    = tx_r;
  assign busy_flag  = busy_r;
  assign error_flag = failed_r;

endmodule
